>>> src/lfu_pkg.sv
// lfu_pkg: types and constants shared by the LFU cache controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
package lfu_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_INSERT,
    ST_OUT
  } state_t;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic update_hit;
    logic evict;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic hit;
    logic is_put;
    logic need_evict;
    logic have_victim;
    logic can_insert;
  } sts_t;
endpackage

>>> src/lfu_ctrl.sv
// lfu_ctrl: sequencer for the LFU cache: scan, evict, insert, deliver.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lfu_pkg::sts_t  sts,
  output lfu_pkg::cmd_t  cmd
);
  lfu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lfu_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::ST_IDLE: if (in_valid) state_next = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          if (sts.hit || !sts.is_put || !sts.can_insert) state_next = lfu_pkg::ST_OUT;
          else if (sts.need_evict) state_next = lfu_pkg::ST_EVICT;
          else state_next = lfu_pkg::ST_INSERT;
        end
      end
      lfu_pkg::ST_EVICT: state_next = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_INSERT: state_next = lfu_pkg::ST_OUT;
      lfu_pkg::ST_OUT: if (!out_stall) state_next = lfu_pkg::ST_IDLE;
      default: state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      lfu_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        cmd.scan_start = in_valid;
      end
      lfu_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.update_hit = sts.scan_last && sts.hit;
      end
      lfu_pkg::ST_EVICT: begin
        cmd.evict = sts.have_victim;
        cmd.scan_start = 1'b1;
      end
      lfu_pkg::ST_INSERT: cmd.insert = 1'b1;
      lfu_pkg::ST_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> src/lfu_dp.sv
// lfu_dp: entry storage, sequential key match and victim search, updates.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
module lfu_dp #(
  parameter int ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    cap_reg,
  input  lfu_pkg::cmd_t cmd,
  output lfu_pkg::sts_t sts,
  input  logic          op,
  input  logic [31:0]   key,
  input  logic [31:0]   value,
  output logic          hit,
  output logic [31:0]   read_value,
  output logic          evicted,
  output logic [31:0]   evicted_key
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] vld;
  logic [31:0] ekey [ENTRIES];
  logic [31:0] eval [ENTRIES];
  logic [31:0] ucnt [ENTRIES];
  logic [IW-1:0] rank [ENTRIES];

  logic r_op;
  logic [31:0] r_key, r_val;
  logic [CW-1:0] idx;
  logic [IW-1:0] slot, vic, frs;
  logic found, vfound, ffound;
  logic [CW-1:0] occ;
  logic [CW-1:0] cap;
  logic [IW-1:0] cur;
  logic [31:0] vcnt;
  logic [IW-1:0] vrank;

  assign cur = idx[IW-1:0];
  assign cap = ({27'd0, cap_reg} > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_reg);

  assign sts.scan_last = (idx == CW'(ENTRIES - 1));
  assign sts.hit = found || (vld[cur] && ekey[cur] == r_key);
  assign sts.is_put = (r_op == lfu_pkg::OP_PUT);
  assign sts.can_insert = (cap != '0);
  // occupancy including the entry under the scan pointer on the last step
  assign sts.need_evict = ((occ + CW'(vld[cur])) >= cap);
  assign sts.have_victim = vfound;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= op;
      r_key <= key;
      r_val <= value;
      hit <= 1'b0;
      read_value <= '0;
      evicted <= 1'b0;
      evicted_key <= '0;
    end
    if (cmd.scan_start) begin
      idx <= '0;
      found <= 1'b0;
      vfound <= 1'b0;
      ffound <= 1'b0;
      occ <= '0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) idx <= idx + 1'b1;
      if (vld[cur]) begin
        occ <= occ + 1'b1;
        if (!found && ekey[cur] == r_key) begin
          found <= 1'b1;
          slot <= cur;
        end
        if (!vfound || ucnt[cur] < vcnt || (ucnt[cur] == vcnt && rank[cur] > vrank)) begin
          vfound <= 1'b1;
          vic <= cur;
          vcnt <= ucnt[cur];
          vrank <= rank[cur];
        end
      end else if (!ffound) begin
        ffound <= 1'b1;
        frs <= cur;
      end
    end
    if (cmd.update_hit) begin
      hit <= 1'b1;
      if (found) begin
        if (r_op == lfu_pkg::OP_GET) read_value <= eval[slot];
      end else if (r_op == lfu_pkg::OP_GET) read_value <= eval[cur];
    end
    if (cmd.evict && !evicted) begin
      evicted <= 1'b1;
      evicted_key <= ekey[vic];
    end
  end

  logic [IW-1:0] hs;
  assign hs = found ? slot : cur;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (cmd.evict) vld[vic] <= 1'b0;
    else if (cmd.insert && ffound) vld[frs] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.update_hit) begin
        if (IW'(i) == hs) begin
          rank[i] <= '0;
          if (ucnt[i] != 32'hFFFF_FFFF) ucnt[i] <= ucnt[i] + 1'b1;
          if (r_op == lfu_pkg::OP_PUT) eval[i] <= r_val;
        end else if (vld[i] && rank[i] < rank[hs]) rank[i] <= rank[i] + 1'b1;
      end else if (cmd.evict) begin
        if (vld[i] && rank[i] > rank[vic]) rank[i] <= rank[i] - 1'b1;
      end else if (cmd.insert && ffound) begin
        if (IW'(i) == frs) begin
          ekey[i] <= r_key;
          eval[i] <= r_val;
          ucnt[i] <= 32'd1;
          rank[i] <= '0;
        end else if (vld[i]) rank[i] <= rank[i] + 1'b1;
      end
    end
  end
endmodule

>>> src/lfu_cache_lookup_replace.sv
// LFU key-value cache: each beat is loaded, then the entries are scanned one per
// cycle (key match, occupancy, victim and free slot); a put that misses is then
// inserted if capacity allows, and the result is delivered; each eviction adds a
// rescan of the entries.
`timescale 1ns / 1ps
module lfu_cache_lookup_replace #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [31:0] read_value,
  output logic        evicted,
  output logic [31:0] evicted_key
);
  logic [4:0] capacity;
  lfu_pkg::cmd_t cmd;
  lfu_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) capacity <= 5'd16;
    else if (psel && penable && pwrite && paddr == 1'b0) capacity <= pwdata[4:0];
  end

  lfu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  lfu_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cap_reg(capacity), .cmd(cmd), .sts(sts),
    .op(op), .key(key), .value(value), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key)
  );
endmodule

>>> sim/tb_lfu_cache_lookup_replace.sv
// Self-checking testbench for lfu_cache_lookup_replace: random and directed get/put
// beats checked against an LFU/LRU cache predictor kept in the testbench.
// Depends on lfu_pkg and the lfu_cache_lookup_replace RTL.
`timescale 1ns / 1ps
module tb_lfu_cache_lookup_replace;

  localparam int NSLOT = 16;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = lfu_pkg::OP_GET;
  logic [31:0] key = '0, value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit, evicted;
  logic [31:0] read_value, evicted_key;

  lfu_cache_lookup_replace dut (.*);

  always #1 clk = ~clk;

  access_t  pending_q[$];
  outcome_t expected_q[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_start = 0, hold_left = 0;
  int fails = 0, beats_in = 0, beats_out = 0, hits_seen = 0, evicts_seen = 0;
  int wdog = 0;

  logic        slot_valid[NSLOT];
  logic [31:0] slot_key[NSLOT], slot_value[NSLOT], slot_count[NSLOT];
  int          slot_age[NSLOT];
  logic [4:0]  cap_reg = 5'd16;

  logic [31:0] key_pool[24];

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int s, f, v, n, rk;
    int unsigned eff;
    r = '0;
    s = -1;
    f = -1;
    eff = (cap_reg > NSLOT) ? NSLOT : cap_reg;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && slot_valid[i] && slot_key[i] == a.key) s = i;
    if (s >= 0) begin
      r.hit = 1'b1;
      if (a.op == lfu_pkg::OP_GET) r.read_value = slot_value[s];
      else slot_value[s] = a.value;
      if (slot_count[s] != 32'hFFFF_FFFF) slot_count[s]++;
      rk = slot_age[s];
      for (int i = 0; i < NSLOT; i++)
        if (slot_valid[i] && i != s && slot_age[i] < rk) slot_age[i]++;
      slot_age[s] = 0;
    end else if (a.op == lfu_pkg::OP_PUT && eff != 0) begin
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (slot_valid[i]) n++;
      while (n >= eff) begin
        v = -1;
        for (int i = 0; i < NSLOT; i++)
          if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
              (slot_count[i] == slot_count[v] && slot_age[i] > slot_age[v]))) v = i;
        if (v < 0) break;
        if (!r.evicted) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[v];
        end
        rk = slot_age[v];
        slot_valid[v] = 1'b0;
        for (int i = 0; i < NSLOT; i++)
          if (slot_valid[i] && slot_age[i] > rk) slot_age[i]--;
        n--;
      end
      for (int i = 0; i < NSLOT; i++) if (f < 0 && !slot_valid[i]) f = i;
      if (f >= 0) begin
        for (int i = 0; i < NSLOT; i++) if (slot_valid[i]) slot_age[i]++;
        slot_valid[f] = 1'b1;
        slot_key[f] = a.key;
        slot_value[f] = a.value;
        slot_count[f] = 32'd1;
        slot_age[f] = 0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fails++;
    $display("MISMATCH beat %0d %s: got %h expected %h", beats_out, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    access_t nxt;
    logic drive;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_q.push_back(cache_access('{op, key, value}));
        beats_in++;
      end
      drive = pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct;
      if (drive) begin
        nxt = pending_q.pop_front();
        op <= nxt.op;
        key <= nxt.key;
        value <= nxt.value;
      end
      in_valid <= drive;
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, beats in", 32'(beats_out), 32'(beats_in));
      end else begin
        want = expected_q.pop_front();
        if (hit != want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (read_value != want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (evicted != want.evicted)
          report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
        if (evicted_key != want.evicted_key)
          report_mismatch("evicted_key", evicted_key, want.evicted_key);
        hits_seen += int'(hit);
        evicts_seen += int'(evicted);
      end
    end
    if (hold_start > 0) begin
      hold_left <= hold_start;
      hold_start <= 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("lfu_cache_lookup_replace regression: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = d[4:0];
  endtask

  function automatic access_t rand_access();
    access_t a;
    a.op = 1'($urandom_range(1));
    a.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom;
    a.value = $urandom;
    return a;
  endfunction

  initial begin
    int caps[8];
    caps = '{16, 1, 0, 3, 31, 8, 2, 16};
    for (int i = 0; i < NSLOT; i++) slot_valid[i] = 1'b0;
    for (int i = 0; i < 24; i++) key_pool[i] = i;
    key_pool[20] = 32'h8000_0000;
    key_pool[21] = 32'h7FFF_FFFF;
    key_pool[22] = 32'hFFFF_FFFF;
    key_pool[23] = 32'hA5A5_5A5A;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_capacity(32'd16);

    // directed: extremes, hits, overwrite, miss, fill then LFU/LRU eviction
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0});
    pending_q.push_back('{lfu_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF});
    pending_q.push_back('{lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0});
    pending_q.push_back('{lfu_pkg::OP_GET, 32'h1234_5678, 32'h0});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'h0, 32'h5555_AAAA});
    pending_q.push_back('{lfu_pkg::OP_GET, 32'h0, 32'h0});
    for (int i = 1; i <= 13; i++) pending_q.push_back('{lfu_pkg::OP_PUT, i, i * 7});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'd100, 32'd1});
    pending_q.push_back('{lfu_pkg::OP_PUT, 32'd101, 32'd2});
    pending_q.push_back('{lfu_pkg::OP_GET, 32'd1, 32'd0});
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? 51 : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? 51 : 0;
      if (p % 4 == 3) begin
        send_idle_pct = 24;
        recv_stall_pct = 24;
      end
      if (p == 1 || p == 5) begin
        @(posedge clk);
        hold_start <= 300;
      end
      for (int i = 0; i < 90; i++) pending_q.push_back(rand_access());
      wait_drained();
      for (int i = 0; i < 85; i++) pending_q.push_back(rand_access());
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d beats in, %0d results (%0d hits, %0d evictions)",
             beats_in, beats_out, hits_seen, evicts_seen);
    $display("capacities 0..31 with idle and stall phases, %0d mismatches", fails);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("lfu_cache_lookup_replace regression: pass");
    end else begin
      $display("lfu_cache_lookup_replace regression: fail");
    end
    $finish;
  end
endmodule
